// File: rtl/mcw_pkg.sv
// ----------------------------------------------------------------------------
// mcw_pkg
// Shared types and constants for the minimum covering window block.
// ----------------------------------------------------------------------------
package mcw_pkg;

    // Sizes of the stores and the count table
    localparam int ALPHABET  = 128;
    localparam int SRC_DEPTH = 4096;
    localparam int TGT_MAX   = 255;

    // Field and register widths
    localparam int SYM_W  = 7;                   // character code
    localparam int ADDR_W = $clog2(SRC_DEPTH);   // source store address
    localparam int POS_W  = ADDR_W + 1;          // window bounds and lengths
    localparam int CNT_W  = POS_W + 1;           // signed need count
    localparam int MISS_W = 8;                   // characters still missing

    // Operation codes carried on the input tuser
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_TARGET = 2'd1,
        OP_SOURCE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear;      // empty the count table and restart
        logic tgt_issue;  // latch a target character
        logic tgt_upd;    // add one to its need count
        logic src_issue;  // store a source character and widen the window
        logic src_upd;    // take one from its need count
        logic best_chk;   // compare window with best, read leftmost char
        logic shr_upd;    // drop leftmost character from the window
        logic set_ovf;    // source store full, note overflow
        logic load_out;   // load the result register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic store_full;  // no room left in the source store
        logic tgt_ok;      // a target character may still be loaded
        logic had_target;  // a target was loaded when this char arrived
        logic shrink;      // window covers the target and is not empty
    } t_sts;

endpackage

// File: rtl/mcw_ctrl.sv
// ----------------------------------------------------------------------------
// mcw_ctrl
// Sequencer for the minimum covering window block: handshakes and the
// order of datapath steps for each item.
// ----------------------------------------------------------------------------
module mcw_ctrl
    import mcw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_valid,
    input  logic [1:0] i_op,
    output logic       o_s_ready,
    output logic       o_m_valid,
    input  logic       i_m_ready,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_TGT_UPD = 7'b0000010,
        S_SRC_UPD = 7'b0000100,
        S_CHECK   = 7'b0001000,
        S_SHR_RD  = 7'b0010000,
        S_SHR_UPD = 7'b0100000,
        S_EMIT    = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_m_valid;
    logic   w_accept;
    logic   w_slot_free;

    assign o_s_ready   = (r_state == S_IDLE);
    assign w_accept    = i_s_valid && o_s_ready;
    assign w_slot_free = !r_m_valid || i_m_ready;
    assign o_m_valid   = r_m_valid;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (t_op'(i_op))
                        OP_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        OP_TARGET: begin
                            if (i_sts.tgt_ok) begin
                                o_cmd.tgt_issue = 1'b1;
                                n_state = S_TGT_UPD;
                            end
                        end
                        OP_SOURCE: begin
                            if (i_sts.store_full) begin
                                o_cmd.set_ovf = 1'b1;
                                n_state = S_EMIT;
                            end else begin
                                o_cmd.src_issue = 1'b1;
                                n_state = S_SRC_UPD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_TGT_UPD: begin
                o_cmd.tgt_upd = 1'b1;
                n_state = S_IDLE;
            end
            S_SRC_UPD: begin
                o_cmd.src_upd = 1'b1;
                n_state = i_sts.had_target ? S_CHECK : S_EMIT;
            end
            S_CHECK: begin
                if (i_sts.shrink) begin
                    o_cmd.best_chk = 1'b1;
                    n_state = S_SHR_RD;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SHR_RD: begin
                // Leftmost character is on the store output; its count is read now
                n_state = S_SHR_UPD;
            end
            S_SHR_UPD: begin
                o_cmd.shr_upd = 1'b1;
                n_state = S_CHECK;
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register and result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/mcw_dpath.sv
// ----------------------------------------------------------------------------
// mcw_dpath
// Datapath for the minimum covering window block: count table, source
// store, window bounds, best window and the result register.
// ----------------------------------------------------------------------------
module mcw_dpath
    import mcw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SYM_W-1:0]  i_symbol,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output logic [ADDR_W-1:0] o_best_start,
    output logic [POS_W-1:0]  o_best_len,
    output logic              o_found,
    output logic              o_overflow
);

    // Count table with per-entry valid bits, and the source store
    logic signed [CNT_W-1:0] r_need_mem [ALPHABET];
    logic [ALPHABET-1:0]     r_need_vld;
    logic signed [CNT_W-1:0] r_need_rd;
    logic                    r_need_rd_vld;
    logic [SYM_W-1:0]        r_store_mem [SRC_DEPTH];
    logic [SYM_W-1:0]        r_store_rd;

    // Control and window registers
    logic [SYM_W-1:0]  r_sym;
    logic [MISS_W-1:0] r_missing;
    logic [POS_W-1:0]  r_left;
    logic [POS_W-1:0]  r_right;
    logic [ADDR_W-1:0] r_best_pos;
    logic [POS_W-1:0]  r_best_len;
    logic              r_have;
    logic              r_started;
    logic              r_ovf;
    logic              r_had;
    logic              r_shr_rd;   // cycle after best_chk: leftmost count is read

    logic [SYM_W-1:0]        w_need_raddr;
    logic [SYM_W-1:0]        w_need_waddr;
    logic signed [CNT_W-1:0] w_cnt;
    logic signed [CNT_W-1:0] n_cnt;
    logic                    w_need_we;
    logic [POS_W-1:0]        w_span;

    // Count lookup: an entry not written since clear reads as zero
    assign w_cnt        = r_need_rd_vld ? r_need_rd : '0;
    assign w_need_raddr = r_shr_rd ? r_store_rd : i_symbol;
    assign w_need_waddr = i_cmd.shr_upd ? r_store_rd : r_sym;
    assign w_need_we    = i_cmd.tgt_upd || i_cmd.src_upd || i_cmd.shr_upd;
    assign n_cnt        = i_cmd.src_upd ? (w_cnt - CNT_W'(1)) : (w_cnt + CNT_W'(1));
    assign w_span       = r_right - r_left;

    // Status to the controller
    assign o_sts.store_full = (r_right >= POS_W'(SRC_DEPTH));
    assign o_sts.tgt_ok     = !r_started && (r_missing < MISS_W'(TGT_MAX));
    assign o_sts.had_target = r_had;
    assign o_sts.shrink     = (r_missing == '0) && (r_left < r_right);

    // Count table memory
    always_ff @(posedge i_clk) begin
        if (w_need_we) begin
            r_need_mem[w_need_waddr] <= n_cnt;
        end
        r_need_rd <= r_need_mem[w_need_raddr];
    end

    // Valid bits of the count table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_need_vld    <= '0;
            r_need_rd_vld <= 1'b0;
        end else begin
            r_need_rd_vld <= r_need_vld[w_need_raddr];
            if (w_need_we) begin
                r_need_vld[w_need_waddr] <= 1'b1;
            end
        end
    end

    // Source store memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.src_issue) begin
            r_store_mem[r_right[ADDR_W-1:0]] <= i_symbol;
        end
        if (i_cmd.best_chk) begin
            r_store_rd <= r_store_mem[r_left[ADDR_W-1:0]];
        end
    end

    // Latched symbol
    always_ff @(posedge i_clk) begin
        if (i_cmd.tgt_issue || i_cmd.src_issue) begin
            r_sym <= i_symbol;
        end
    end

    // Window bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_missing  <= '0;
            r_left     <= '0;
            r_right    <= '0;
            r_best_pos <= '0;
            r_best_len <= '0;
            r_have     <= 1'b0;
            r_started  <= 1'b0;
            r_ovf      <= 1'b0;
            r_had      <= 1'b0;
            r_shr_rd   <= 1'b0;
        end else begin
            r_shr_rd <= i_cmd.best_chk;
            if (i_cmd.tgt_upd) begin
                r_missing <= r_missing + MISS_W'(1);
            end
            if (i_cmd.src_issue) begin
                r_right   <= r_right + POS_W'(1);
                r_started <= 1'b1;
                r_had     <= (r_missing != '0);
            end
            if (i_cmd.set_ovf) begin
                r_ovf     <= 1'b1;
                r_started <= 1'b1;
            end
            if (i_cmd.src_upd && (w_cnt > 0) && (r_missing != '0)) begin
                r_missing <= r_missing - MISS_W'(1);
            end
            // Strictly shorter windows only, so ties keep the earliest
            if (i_cmd.best_chk && (!r_have || (w_span < r_best_len))) begin
                r_best_len <= w_span;
                r_best_pos <= r_left[ADDR_W-1:0];
                r_have     <= 1'b1;
            end
            if (i_cmd.shr_upd) begin
                r_left <= r_left + POS_W'(1);
                if (w_cnt == '0) begin
                    r_missing <= r_missing + MISS_W'(1);
                end
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_best_start <= r_best_pos;
            o_best_len   <= r_best_len;
            o_found      <= r_have;
            o_overflow   <= r_ovf;
        end
    end

    // Window bounds stay ordered and within the store, missing count within TGT_MAX, best len nonzero
    a_left_le_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= r_right)
        else $error("window left bound passed right bound");
    a_right_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_right <= POS_W'(SRC_DEPTH))
        else $error("window right bound beyond source store");
    a_missing_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_missing <= MISS_W'(TGT_MAX))
        else $error("missing count exceeds target limit");
    a_best_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |-> (r_best_len != '0))
        else $error("best window recorded with zero length");

endmodule

// File: rtl/minimum_covering_window.sv
// A source item, unless the store is full, passes the source update and, if a
// target was loaded, a check and for each character dropped from the left of
// the window a read, an update and another check before its result; each
// character is dropped once. One item is in work at a time.
// Reset clears control state and the count-table valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// minimum_covering_window
// Streams a character source and reports after each source character the
// shortest window so far that covers a loaded target multiset.
// ----------------------------------------------------------------------------
module minimum_covering_window
    import mcw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [6:0] symbol
    input  logic [1:0]  i_s_tuser,   // [1:0] operation
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [11:0] best_start, [24:12] best_len
    output logic [1:0]  o_m_tuser    // [0] found, [1] overflow
);

    t_cmd              w_cmd;
    t_sts              w_sts;
    logic [ADDR_W-1:0] w_best_start;
    logic [POS_W-1:0]  w_best_len;
    logic              w_found;
    logic              w_overflow;

    // Sequencer
    mcw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .i_op      (i_s_tuser),
        .o_s_ready (o_s_tready),
        .o_m_valid (o_m_tvalid),
        .i_m_ready (i_m_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    // Tables, window and result register
    mcw_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_symbol     (i_s_tdata[SYM_W-1:0]),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_best_start (w_best_start),
        .o_best_len   (w_best_len),
        .o_found      (w_found),
        .o_overflow   (w_overflow)
    );

    // Pack the result item
    assign o_m_tdata = {7'd0, w_best_len, w_best_start};
    assign o_m_tuser = {w_overflow, w_found};

endmodule
